// ===== hw/rtl/tpc_pkg.sv =====
`timescale 1ns / 1ps

package tpc_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int AW            = $clog2(TABLE_ENTRIES);
  localparam int PC_W          = 7;

  // op codes
  localparam logic [3:0] OP_INIT  = 4'd0;
  localparam logic [3:0] OP_BYTE  = 4'd1;
  localparam logic [3:0] OP_U16   = 4'd2;
  localparam logic [3:0] OP_U32   = 4'd3;
  localparam logic [3:0] OP_U64   = 4'd4;
  localparam logic [3:0] OP_SBYTE = 4'd5;
  localparam logic [3:0] OP_S16   = 4'd6;
  localparam logic [3:0] OP_S32   = 4'd7;
  localparam logic [3:0] OP_S64   = 4'd8;

  // program entry points and shared tails
  localparam logic [PC_W-1:0] PC_INIT      = 7'd0;
  localparam logic [PC_W-1:0] PC_IDLE_DONE = 7'd1;
  localparam logic [PC_W-1:0] PC_BYTE      = 7'd2;
  localparam logic [PC_W-1:0] PC_U16       = 7'd5;
  localparam logic [PC_W-1:0] PC_U32       = 7'd12;
  localparam logic [PC_W-1:0] PC_U32_BUILD = 7'd21;
  localparam logic [PC_W-1:0] PC_U32_SEED  = 7'd26;
  localparam logic [PC_W-1:0] PC_U64       = 7'd31;
  localparam logic [PC_W-1:0] PC_U64_BUILD = 7'd48;
  localparam logic [PC_W-1:0] PC_U64_SEED  = 7'd57;
  localparam logic [PC_W-1:0] PC_LAST      = 7'd65;

  typedef enum logic [2:0] {
    ST_READ, ST_DRAW, ST_INIT, ST_JUMP, ST_JSEED, ST_DONE
  } step_t;

  typedef enum logic [1:0] {SRC_CONST, SRC_SEL, SRC_T, SRC_K} src_t;
  typedef enum logic [1:0] {DST_T, DST_K, DST_WORD, DST_BYTE} dst_t;
  typedef enum logic [1:0] {MK_NONE, MK_16, MK_32, MK_64} mask_t;

  typedef struct packed {
    step_t           step;
    src_t            src;
    dst_t            dst;
    logic [1:0]      idx;
    logic [3:0]      cval;
    logic            use_seed;
    mask_t           mask;
    logic [PC_W-1:0] target;
  } ucw_t;

  typedef struct packed {
    logic            active;
    logic            start;
    logic            done_go;
    logic [PC_W-1:0] pc;
    ucw_t            cw;
  } ctl_t;

  typedef struct packed {
    logic seeded;
    logic rsp_valid;
  } stat_t;

  localparam logic [7:0] PERM_ROM [TABLE_ENTRIES] = '{
    8'd0,   8'd8,   8'd109, 8'd220, 8'd222, 8'd241, 8'd149, 8'd107, 8'd75,  8'd248,
    8'd254, 8'd140, 8'd16,  8'd66,  8'd74,  8'd21,  8'd211, 8'd47,  8'd80,  8'd242,
    8'd154, 8'd27,  8'd205, 8'd117, 8'd157, 8'd89,  8'd208, 8'd36,  8'd95,  8'd110,
    8'd85,  8'd48,  8'd212, 8'd29,  8'd32,  8'd179, 8'd22,  8'd79,  8'd200, 8'd119,
    8'd28,  8'd188, 8'd234, 8'd23,  8'd202, 8'd55,  8'd68,  8'd145, 8'd62,  8'd131,
    8'd184, 8'd190, 8'd91,  8'd127, 8'd152, 8'd217, 8'd12,  8'd104, 8'd25,  8'd178,
    8'd252, 8'd182, 8'd83,  8'd177, 8'd141, 8'd169, 8'd4,   8'd81,  8'd181, 8'd35,
    8'd199, 8'd42,  8'd39,  8'd227, 8'd155, 8'd124, 8'd225, 8'd193, 8'd219, 8'd93,
    8'd122, 8'd88,  8'd249, 8'd1,   8'd210, 8'd143, 8'd70,  8'd174, 8'd46,  8'd246,
    8'd65,  8'd53,  8'd163, 8'd5,   8'd168, 8'd135, 8'd2,   8'd235, 8'd67,  8'd92,
    8'd20,  8'd207, 8'd138, 8'd233, 8'd69,  8'd166, 8'd78,  8'd176, 8'd173, 8'd160,
    8'd148, 8'd113, 8'd94,  8'd161, 8'd41,  8'd50,  8'd239, 8'd49,  8'd111, 8'd164,
    8'd134, 8'd60,  8'd189, 8'd37,  8'd171, 8'd13,  8'd214, 8'd156, 8'd11,  8'd56,
    8'd204, 8'd215, 8'd44,  8'd229, 8'd73,  8'd146, 8'd77,  8'd61,  8'd218, 8'd64,
    8'd209, 8'd106, 8'd63,  8'd105, 8'd195, 8'd86,  8'd96,  8'd203, 8'd121, 8'd101,
    8'd170, 8'd247, 8'd137, 8'd213, 8'd34,  8'd250, 8'd108, 8'd7,   8'd255, 8'd237,
    8'd129, 8'd40,  8'd144, 8'd18,  8'd112, 8'd142, 8'd103, 8'd10,  8'd24,  8'd223,
    8'd51,  8'd120, 8'd198, 8'd58,  8'd172, 8'd82,  8'd128, 8'd3,   8'd132, 8'd30,
    8'd150, 8'd115, 8'd72,  8'd224, 8'd97,  8'd206, 8'd133, 8'd45,  8'd240, 8'd90,
    8'd151, 8'd114, 8'd59,  8'd33,  8'd159, 8'd228, 8'd191, 8'd139, 8'd153, 8'd98,
    8'd125, 8'd196, 8'd15,  8'd245, 8'd194, 8'd253, 8'd54,  8'd14,  8'd6,   8'd226,
    8'd71,  8'd17,  8'd180, 8'd147, 8'd186, 8'd87,  8'd244, 8'd130, 8'd230, 8'd102,
    8'd123, 8'd251, 8'd26,  8'd162, 8'd192, 8'd201, 8'd52,  8'd231, 8'd232, 8'd76,
    8'd31,  8'd221, 8'd84,  8'd167, 8'd216, 8'd165, 8'd158, 8'd116, 8'd197, 8'd38,
    8'd183, 8'd43,  8'd185, 8'd175, 8'd19,  8'd238, 8'd100, 8'd243, 8'd118, 8'd9,
    8'd187, 8'd136, 8'd57,  8'd99,  8'd236, 8'd126
  };

  function automatic logic [7:0] rom_at(input logic [AW-1:0] a);
    return PERM_ROM[a];
  endfunction

  function automatic logic [63:0] seed_mask(input mask_t m, input logic [63:0] s);
    logic [63:0] r;
    case (m)
      MK_16:   r = {48'd0, s[15:0]};
      MK_32:   r = {32'd0, s[31:0]};
      MK_64:   r = s;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [PC_W-1:0] entry_pc(input logic [3:0] op);
    logic [PC_W-1:0] p;
    case (op)
      OP_INIT:  p = PC_INIT;
      OP_BYTE:  p = PC_BYTE;
      OP_SBYTE: p = PC_BYTE;
      OP_U16:   p = PC_U16;
      OP_S16:   p = PC_U16;
      OP_U32:   p = PC_U32;
      OP_S32:   p = PC_U32;
      OP_U64:   p = PC_U64;
      OP_S64:   p = PC_U64;
      default:  p = PC_IDLE_DONE;
    endcase
    return p;
  endfunction

  // control word builders
  function automatic ucw_t uc_rd(input src_t sr, input logic [1:0] ix, input logic [3:0] cv);
    ucw_t w;
    w      = '0;
    w.step = ST_READ;
    w.src  = sr;
    w.idx  = ix;
    w.cval = cv;
    return w;
  endfunction

  function automatic ucw_t uc_dr(input dst_t ds, input logic [1:0] ix, input logic us);
    ucw_t w;
    w          = '0;
    w.step     = ST_DRAW;
    w.dst      = ds;
    w.idx      = ix;
    w.use_seed = us;
    return w;
  endfunction

  function automatic ucw_t uc_ctl(input step_t st, input mask_t mk,
                                  input logic [PC_W-1:0] tg);
    ucw_t w;
    w        = '0;
    w.step   = st;
    w.mask   = mk;
    w.target = tg;
    return w;
  endfunction

  // microprogram
  function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
    ucw_t w;
    case (pc)
      7'd0:  w = uc_ctl(ST_INIT, MK_NONE, '0);
      7'd1:  w = uc_ctl(ST_DONE, MK_NONE, '0);
      // single byte, plain or seeded
      7'd2:  w = uc_rd(SRC_SEL, 2'd0, 4'd0);
      7'd3:  w = uc_dr(DST_BYTE, 2'd0, 1'b1);
      7'd4:  w = uc_ctl(ST_DONE, MK_NONE, '0);
      // 16-bit word
      7'd5:  w = uc_rd(SRC_CONST, 2'd0, 4'd0);
      7'd6:  w = uc_dr(DST_T, 2'd0, 1'b0);
      7'd7:  w = uc_rd(SRC_T, 2'd0, 4'd0);
      7'd8:  w = uc_dr(DST_K, 2'd0, 1'b1);
      7'd9:  w = uc_rd(SRC_K, 2'd0, 4'd0);
      7'd10: w = uc_dr(DST_WORD, 2'd0, 1'b1);
      7'd11: w = uc_ctl(ST_DONE, MK_16, '0);
      // 32-bit word
      7'd12: w = uc_ctl(ST_JSEED, MK_NONE, PC_U32_SEED);
      7'd13: w = uc_rd(SRC_CONST, 2'd0, 4'd0);
      7'd14: w = uc_dr(DST_T, 2'd0, 1'b0);
      7'd15: w = uc_rd(SRC_T, 2'd0, 4'd0);
      7'd16: w = uc_dr(DST_K, 2'd0, 1'b1);
      7'd17: w = uc_rd(SRC_CONST, 2'd0, 4'd0);
      7'd18: w = uc_dr(DST_T, 2'd0, 1'b0);
      7'd19: w = uc_rd(SRC_T, 2'd0, 4'd0);
      7'd20: w = uc_dr(DST_K, 2'd1, 1'b1);
      7'd21: w = uc_rd(SRC_K, 2'd1, 4'd0);
      7'd22: w = uc_dr(DST_WORD, 2'd0, 1'b1);
      7'd23: w = uc_rd(SRC_K, 2'd0, 4'd0);
      7'd24: w = uc_dr(DST_WORD, 2'd1, 1'b1);
      7'd25: w = uc_ctl(ST_DONE, MK_32, '0);
      7'd26: w = uc_rd(SRC_CONST, 2'd0, 4'd3);
      7'd27: w = uc_dr(DST_K, 2'd0, 1'b1);
      7'd28: w = uc_rd(SRC_CONST, 2'd0, 4'd4);
      7'd29: w = uc_dr(DST_K, 2'd1, 1'b1);
      7'd30: w = uc_ctl(ST_JUMP, MK_NONE, PC_U32_BUILD);
      // 64-bit word
      7'd31: w = uc_ctl(ST_JSEED, MK_NONE, PC_U64_SEED);
      7'd32: w = uc_rd(SRC_CONST, 2'd0, 4'd0);
      7'd33: w = uc_dr(DST_T, 2'd0, 1'b0);
      7'd34: w = uc_rd(SRC_T, 2'd0, 4'd0);
      7'd35: w = uc_dr(DST_K, 2'd0, 1'b1);
      7'd36: w = uc_rd(SRC_CONST, 2'd0, 4'd0);
      7'd37: w = uc_dr(DST_T, 2'd0, 1'b0);
      7'd38: w = uc_rd(SRC_T, 2'd0, 4'd0);
      7'd39: w = uc_dr(DST_K, 2'd1, 1'b1);
      7'd40: w = uc_rd(SRC_CONST, 2'd0, 4'd0);
      7'd41: w = uc_dr(DST_T, 2'd0, 1'b0);
      7'd42: w = uc_rd(SRC_T, 2'd0, 4'd0);
      7'd43: w = uc_dr(DST_K, 2'd2, 1'b1);
      7'd44: w = uc_rd(SRC_CONST, 2'd0, 4'd0);
      7'd45: w = uc_dr(DST_T, 2'd0, 1'b0);
      7'd46: w = uc_rd(SRC_T, 2'd0, 4'd0);
      7'd47: w = uc_dr(DST_K, 2'd3, 1'b1);
      7'd48: w = uc_rd(SRC_K, 2'd3, 4'd0);
      7'd49: w = uc_dr(DST_WORD, 2'd0, 1'b1);
      7'd50: w = uc_rd(SRC_K, 2'd2, 4'd0);
      7'd51: w = uc_dr(DST_WORD, 2'd1, 1'b1);
      7'd52: w = uc_rd(SRC_K, 2'd1, 4'd0);
      7'd53: w = uc_dr(DST_WORD, 2'd2, 1'b1);
      7'd54: w = uc_rd(SRC_K, 2'd0, 4'd0);
      7'd55: w = uc_dr(DST_WORD, 2'd3, 1'b1);
      7'd56: w = uc_ctl(ST_DONE, MK_64, '0);
      7'd57: w = uc_rd(SRC_CONST, 2'd0, 4'd5);
      7'd58: w = uc_dr(DST_K, 2'd0, 1'b1);
      7'd59: w = uc_rd(SRC_CONST, 2'd0, 4'd6);
      7'd60: w = uc_dr(DST_K, 2'd1, 1'b1);
      7'd61: w = uc_rd(SRC_CONST, 2'd0, 4'd7);
      7'd62: w = uc_dr(DST_K, 2'd2, 1'b1);
      7'd63: w = uc_rd(SRC_CONST, 2'd0, 4'd8);
      7'd64: w = uc_dr(DST_K, 2'd3, 1'b1);
      7'd65: w = uc_ctl(ST_JUMP, MK_NONE, PC_U64_BUILD);
      default: w = uc_ctl(ST_DONE, MK_NONE, '0);
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/tpc_useq.sv =====
`timescale 1ns / 1ps

module tpc_useq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic [3:0]           op,
  input  logic                 rsp_ready,
  input  tpc_pkg::stat_t       stat,
  output logic                 req_ready,
  output tpc_pkg::ctl_t        ctl
);

  logic                        busy;
  logic [tpc_pkg::PC_W-1:0]    pc;
  logic [tpc_pkg::PC_W-1:0]    pc_next;
  tpc_pkg::ucw_t               cw;
  logic                        start;
  logic                        done_go;

  assign cw        = tpc_pkg::ucode(pc);
  assign req_ready = !busy;
  assign start     = req_valid && !busy;
  // done holds while the previous word is still waiting at the output
  assign done_go   = busy && (cw.step == tpc_pkg::ST_DONE) &&
                     (!stat.rsp_valid || rsp_ready);

  always_comb begin
    case (cw.step)
      tpc_pkg::ST_JUMP:  pc_next = cw.target;
      tpc_pkg::ST_JSEED: pc_next = stat.seeded ? cw.target : pc + 1'b1;
      tpc_pkg::ST_DONE:  pc_next = pc;
      default:           pc_next = pc + 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= tpc_pkg::PC_IDLE_DONE;
    end else if (start) begin
      busy <= 1'b1;
      pc   <= tpc_pkg::entry_pc(op);
    end else if (busy) begin
      if (done_go) begin
        busy <= 1'b0;
      end
      pc <= pc_next;
    end
  end

  assign ctl.active  = busy;
  assign ctl.start   = start;
  assign ctl.done_go = done_go;
  assign ctl.pc      = pc;
  assign ctl.cw      = cw;

endmodule

// ===== hw/rtl/tpc_datapath.sv =====
`timescale 1ns / 1ps

module tpc_datapath (
  input  logic           clk,
  input  logic           rst,
  input  tpc_pkg::ctl_t  ctl,
  input  logic [3:0]     op,
  input  logic [7:0]     cursor_select,
  input  logic [63:0]    seed,
  input  logic           rsp_ready,
  output tpc_pkg::stat_t stat,
  output logic           rsp_valid,
  output logic [63:0]    value
);

  logic [7:0]                     mem [tpc_pkg::TABLE_ENTRIES];
  logic [tpc_pkg::TABLE_ENTRIES-1:0] vbits;
  logic                           base;
  logic [7:0]                     rdata;

  logic                           seeded;
  logic [7:0]                     sel;
  logic [63:0]                    seed_r;
  logic [tpc_pkg::AW-1:0]         caddr;
  logic [7:0]                     t;
  logic [7:0]                     k [4];
  logic [63:0]                    word;

  logic [tpc_pkg::AW-1:0]         raddr;
  logic [7:0]                     pos;
  logic [7:0]                     sx;
  logic [7:0]                     draw_byte;
  logic [7:0]                     hi_byte;
  logic                           draw_en;
  logic                           read_en;
  logic                           init_en;

  assign read_en = ctl.active && (ctl.cw.step == tpc_pkg::ST_READ);
  assign draw_en = ctl.active && (ctl.cw.step == tpc_pkg::ST_DRAW);
  assign init_en = ctl.active && (ctl.cw.step == tpc_pkg::ST_INIT);

  always_comb begin
    case (ctl.cw.src)
      tpc_pkg::SRC_CONST: raddr = {4'd0, ctl.cw.cval};
      tpc_pkg::SRC_SEL:   raddr = sel;
      tpc_pkg::SRC_T:     raddr = t;
      tpc_pkg::SRC_K:     raddr = k[ctl.cw.idx];
      default:            raddr = '0;
    endcase
  end

  // an unwritten cursor reads as zero after reset, as its rom entry after init
  assign pos       = vbits[caddr] ? rdata : (base ? tpc_pkg::rom_at(caddr) : 8'd0);
  assign sx        = (ctl.cw.use_seed && seeded) ? seed_r[7:0] : 8'd0;
  assign draw_byte = tpc_pkg::rom_at(pos + sx) ^ sx;
  assign hi_byte   = tpc_pkg::rom_at(caddr + sx);

  always_ff @(posedge clk) begin
    if (draw_en) begin
      mem[caddr] <= pos + 8'd1;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vbits     <= '0;
      base      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (init_en) begin
        vbits <= '0;
        base  <= 1'b1;
      end else if (draw_en) begin
        vbits[caddr] <= 1'b1;
      end
      if (ctl.done_go) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      seeded <= (op == tpc_pkg::OP_SBYTE) || (op == tpc_pkg::OP_S16) ||
                (op == tpc_pkg::OP_S32) || (op == tpc_pkg::OP_S64);
      sel    <= cursor_select;
      seed_r <= seed;
      word   <= '0;
    end else if (draw_en) begin
      case (ctl.cw.dst)
        tpc_pkg::DST_T:    t <= draw_byte;
        tpc_pkg::DST_K:    k[ctl.cw.idx] <= draw_byte;
        tpc_pkg::DST_BYTE: word <= {56'd0, draw_byte};
        tpc_pkg::DST_WORD: begin
          word[{ctl.cw.idx, 4'b0000} +: 8]     <= draw_byte;
          word[{ctl.cw.idx, 4'b1000} +: 8]     <= hi_byte;
        end
        default: t <= t;
      endcase
    end
    if (read_en) begin
      caddr <= raddr;
    end
    if (ctl.done_go) begin
      value <= word ^ (seeded ? tpc_pkg::seed_mask(ctl.cw.mask, seed_r) : 64'd0);
    end
  end

  assign stat.seeded    = seeded;
  assign stat.rsp_valid = rsp_valid;

endmodule

// ===== hw/rtl/table_prng_with_cursors_core.sv =====
`timescale 1ns / 1ps
// throughput: one word in flight; each cursor draw is two steps (memory read, then rom
//   lookup and write-back); the input is ready again in the cycle after the result
//   loads; a result still waiting at the output holds the done step
// reset: synchronous, clears sequencer, output valid and cursor valid bits; cursors read 0

module table_prng_with_cursors_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [3:0]  op,
  input  logic [7:0]  cursor_select,
  input  logic [63:0] seed,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [63:0] value
);

  tpc_pkg::ctl_t  ctl;
  tpc_pkg::stat_t stat;

  tpc_useq u_useq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .op        (op),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .req_ready (req_ready),
    .ctl       (ctl)
  );

  tpc_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .op            (op),
    .cursor_select (cursor_select),
    .seed          (seed),
    .rsp_ready     (rsp_ready),
    .stat          (stat),
    .rsp_valid     (rsp_valid),
    .value         (value)
  );

  // one word in flight
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("word accepted while sequencer busy");

  // every draw step follows the read of its cursor
  assert property (@(posedge clk) disable iff (rst)
    ctl.active && (ctl.cw.step == tpc_pkg::ST_DRAW) |->
      $past(ctl.active) && ($past(ctl.cw.step) == tpc_pkg::ST_READ))
    else $error("draw without preceding cursor read");

  // program counter stays inside the microprogram
  assert property (@(posedge clk) disable iff (rst)
    ctl.active |-> (ctl.pc <= tpc_pkg::PC_LAST))
    else $error("microprogram counter out of range");

  // finishing a program presents a word and frees the input
  assert property (@(posedge clk) disable iff (rst)
    ctl.done_go |=> rsp_valid && req_ready)
    else $error("done step did not deliver word");

endmodule

// ===== tb/tb_table_prng_with_cursors_core.sv =====
`timescale 1ns / 1ps

module tb_table_prng_with_cursors_core;

  localparam int CYCLE_LIMIT = 800000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_WORDS = 1900;

  localparam logic [7:0] ROM_TBL [256] = '{
    8'd0,   8'd8,   8'd109, 8'd220, 8'd222, 8'd241, 8'd149, 8'd107, 8'd75,  8'd248,
    8'd254, 8'd140, 8'd16,  8'd66,  8'd74,  8'd21,  8'd211, 8'd47,  8'd80,  8'd242,
    8'd154, 8'd27,  8'd205, 8'd117, 8'd157, 8'd89,  8'd208, 8'd36,  8'd95,  8'd110,
    8'd85,  8'd48,  8'd212, 8'd29,  8'd32,  8'd179, 8'd22,  8'd79,  8'd200, 8'd119,
    8'd28,  8'd188, 8'd234, 8'd23,  8'd202, 8'd55,  8'd68,  8'd145, 8'd62,  8'd131,
    8'd184, 8'd190, 8'd91,  8'd127, 8'd152, 8'd217, 8'd12,  8'd104, 8'd25,  8'd178,
    8'd252, 8'd182, 8'd83,  8'd177, 8'd141, 8'd169, 8'd4,   8'd81,  8'd181, 8'd35,
    8'd199, 8'd42,  8'd39,  8'd227, 8'd155, 8'd124, 8'd225, 8'd193, 8'd219, 8'd93,
    8'd122, 8'd88,  8'd249, 8'd1,   8'd210, 8'd143, 8'd70,  8'd174, 8'd46,  8'd246,
    8'd65,  8'd53,  8'd163, 8'd5,   8'd168, 8'd135, 8'd2,   8'd235, 8'd67,  8'd92,
    8'd20,  8'd207, 8'd138, 8'd233, 8'd69,  8'd166, 8'd78,  8'd176, 8'd173, 8'd160,
    8'd148, 8'd113, 8'd94,  8'd161, 8'd41,  8'd50,  8'd239, 8'd49,  8'd111, 8'd164,
    8'd134, 8'd60,  8'd189, 8'd37,  8'd171, 8'd13,  8'd214, 8'd156, 8'd11,  8'd56,
    8'd204, 8'd215, 8'd44,  8'd229, 8'd73,  8'd146, 8'd77,  8'd61,  8'd218, 8'd64,
    8'd209, 8'd106, 8'd63,  8'd105, 8'd195, 8'd86,  8'd96,  8'd203, 8'd121, 8'd101,
    8'd170, 8'd247, 8'd137, 8'd213, 8'd34,  8'd250, 8'd108, 8'd7,   8'd255, 8'd237,
    8'd129, 8'd40,  8'd144, 8'd18,  8'd112, 8'd142, 8'd103, 8'd10,  8'd24,  8'd223,
    8'd51,  8'd120, 8'd198, 8'd58,  8'd172, 8'd82,  8'd128, 8'd3,   8'd132, 8'd30,
    8'd150, 8'd115, 8'd72,  8'd224, 8'd97,  8'd206, 8'd133, 8'd45,  8'd240, 8'd90,
    8'd151, 8'd114, 8'd59,  8'd33,  8'd159, 8'd228, 8'd191, 8'd139, 8'd153, 8'd98,
    8'd125, 8'd196, 8'd15,  8'd245, 8'd194, 8'd253, 8'd54,  8'd14,  8'd6,   8'd226,
    8'd71,  8'd17,  8'd180, 8'd147, 8'd186, 8'd87,  8'd244, 8'd130, 8'd230, 8'd102,
    8'd123, 8'd251, 8'd26,  8'd162, 8'd192, 8'd201, 8'd52,  8'd231, 8'd232, 8'd76,
    8'd31,  8'd221, 8'd84,  8'd167, 8'd216, 8'd165, 8'd158, 8'd116, 8'd197, 8'd38,
    8'd183, 8'd43,  8'd185, 8'd175, 8'd19,  8'd238, 8'd100, 8'd243, 8'd118, 8'd9,
    8'd187, 8'd136, 8'd57,  8'd99,  8'd236, 8'd126
  };

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  logic [3:0]  op;
  logic [7:0]  cursor_select;
  logic [63:0] seed;
  logic        rsp_valid;
  logic        rsp_ready;
  logic [63:0] value;

  logic [7:0]  cursor_pos [256];
  logic [63:0] expected_values [$];
  int          mismatches;
  int          cycles;
  int          burst_left;
  int          ready_pct;

  table_prng_with_cursors_core DUT (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .op            (op),
    .cursor_select (cursor_select),
    .seed          (seed),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .value         (value)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // one draw: rom byte at cursor plus offset, xored with the offset; cursor post-increments
  function automatic logic [7:0] pull_byte(input logic [7:0] cur, input logic [7:0] s);
    logic [7:0] p;
    logic [7:0] addr;
    p = cursor_pos[cur];
    cursor_pos[cur] = p + 8'd1;
    addr = p + s;
    return ROM_TBL[addr] ^ s;
  endfunction

  function automatic logic [63:0] predict_value(input logic [3:0] o, input logic [7:0] sel,
                                                input logic [63:0] sd);
    logic [7:0]  keys [4];
    logic [7:0]  s;
    logic [7:0]  addr;
    logic [63:0] w;
    logic        seeded;
    int          pairs;
    int          sh;
    w      = '0;
    pairs  = 0;
    seeded = (o == tpc_pkg::OP_S16) || (o == tpc_pkg::OP_S32) || (o == tpc_pkg::OP_S64);
    s      = seeded ? sd[7:0] : 8'd0;
    case (o)
      tpc_pkg::OP_INIT: begin
        for (int i = 0; i < 256; i++) cursor_pos[i] = ROM_TBL[i];
      end
      tpc_pkg::OP_BYTE:  w = {56'd0, pull_byte(sel, 8'd0)};
      tpc_pkg::OP_SBYTE: w = {56'd0, pull_byte(sel, sd[7:0])};
      tpc_pkg::OP_U16, tpc_pkg::OP_U32, tpc_pkg::OP_U64: begin
        pairs = (o == tpc_pkg::OP_U16) ? 1 : (o == tpc_pkg::OP_U32) ? 2 : 4;
        for (int i = 0; i < pairs; i++) keys[i] = pull_byte(pull_byte(8'd0, 8'd0), 8'd0);
      end
      tpc_pkg::OP_S16: begin
        pairs   = 1;
        keys[0] = pull_byte(pull_byte(8'd0, 8'd0), s);
      end
      tpc_pkg::OP_S32: begin
        pairs = 2;
        for (int i = 0; i < 2; i++) keys[i] = pull_byte(8'(3 + i), s);
      end
      tpc_pkg::OP_S64: begin
        pairs = 4;
        for (int i = 0; i < 4; i++) keys[i] = pull_byte(8'(5 + i), s);
      end
      default: w = '0;
    endcase
    // lowest pair comes from the last key, drawn first
    for (int i = pairs - 1; i >= 0; i--) begin
      sh   = (pairs - 1 - i) * 16;
      addr = keys[i] + s;
      w    = w | ({56'd0, pull_byte(keys[i], s)} << sh) | ({56'd0, ROM_TBL[addr]} << (sh + 8));
    end
    if (seeded) begin
      w = w ^ sd;
      if (pairs == 1) w = w & 64'h0000_0000_0000_ffff;
      if (pairs == 2) w = w & 64'h0000_0000_ffff_ffff;
    end
    return w;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  // called at a rising edge; returns at the edge where the word is taken
  task automatic send_word(input logic [3:0] o, input logic [7:0] sel, input logic [63:0] sd);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if ($urandom_range(0, 15) == 0) gap = $urandom_range(20, 40);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_valid     <= 1'b1;
    op            <= o;
    cursor_select <= sel;
    seed          <= sd;
    do @(posedge clk); while (!req_ready);
    expected_values.push_back(predict_value(o, sel, sd));
  endtask

  function automatic logic [63:0] rand_seed();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '1;
    if (r == 1) return '0;
    return {$urandom(), $urandom()};
  endfunction

  // cursors all read zero after reset, so the first draws hit the same cursor twice
  task automatic test_power_on();
    send_word(tpc_pkg::OP_BYTE, 8'd0, 64'd0);
    send_word(tpc_pkg::OP_BYTE, 8'd255, '1);
    send_word(tpc_pkg::OP_U16, 8'd0, 64'd0);
    send_word(tpc_pkg::OP_U32, 8'd255, 64'd0);
    send_word(tpc_pkg::OP_U64, 8'd17, '1);
  endtask

  task automatic test_seed_extremes();
    send_word(tpc_pkg::OP_SBYTE, 8'd255, '1);
    send_word(tpc_pkg::OP_SBYTE, 8'd0, 64'd0);
    send_word(tpc_pkg::OP_S16, 8'd0, '1);
    send_word(tpc_pkg::OP_S32, 8'd0, 64'h8000_0000_0000_00ff);
    send_word(tpc_pkg::OP_S64, 8'd255, '1);
    send_word(tpc_pkg::OP_S64, 8'd0, 64'd0);
  endtask

  task automatic test_unused_codes();
    logic [4:0] c;
    for (c = 5'(tpc_pkg::OP_S64) + 5'd1; c < 5'd16; c++)
      send_word(c[3:0], 8'($urandom()), rand_seed());
  endtask

  task automatic test_cursor_load();
    send_word(tpc_pkg::OP_INIT, 8'd0, 64'd0);
    send_word(tpc_pkg::OP_BYTE, 8'd255, 64'd0);
    send_word(tpc_pkg::OP_S64, 8'd0, {$urandom(), $urandom()});
    send_word(tpc_pkg::OP_U64, 8'd0, 64'd0);
    send_word(tpc_pkg::OP_INIT, 8'd255, '1);
  endtask

  task automatic test_random_mix();
    logic [3:0] o;
    logic [7:0] sel;
    int         r;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 2) o = tpc_pkg::OP_INIT;
      else if (r < 5) o = 4'($urandom_range(int'(tpc_pkg::OP_S64) + 1, 15));
      else o = 4'($urandom_range(int'(tpc_pkg::OP_BYTE), int'(tpc_pkg::OP_S64)));
      // low cursors collide with the word chains more often
      sel = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 9)) : 8'($urandom());
      send_word(o, sel, rand_seed());
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result checker and stall pattern
  always @(posedge clk) begin
    logic [63:0] want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_values.size() == 0) begin
        report_mismatch($sformatf("unexpected word value=%h", value));
      end else begin
        want = expected_values.pop_front();
        if (value !== want) report_mismatch($sformatf("value got %h want %h", value, want));
      end
    end
    if (cycles % 64 == 0) begin
      case ($urandom_range(0, 4))
        0, 1:    ready_pct <= 100;
        2:       ready_pct <= 70;
        3:       ready_pct <= 35;
        default: ready_pct <= 10;
      endcase
    end
    rsp_ready <= ($urandom_range(0, 99) < ready_pct);
  end

  initial begin
    mismatches = 0;
    burst_left = 0;
    for (int i = 0; i < 256; i++) cursor_pos[i] = 8'd0;
    cycles        <= 0;
    ready_pct     <= 100;
    rst           <= 1'b1;
    req_valid     <= 1'b0;
    op            <= tpc_pkg::OP_INIT;
    cursor_select <= '0;
    seed          <= '0;
    rsp_ready     <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_power_on();
    test_seed_extremes();
    test_unused_codes();
    test_cursor_load();
    test_random_mix();

    req_valid <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/tpc_pkg.sv
hw/rtl/tpc_useq.sv
hw/rtl/tpc_datapath.sv
hw/rtl/table_prng_with_cursors_core.sv
tb/tb_table_prng_with_cursors_core.sv
